>>> rtl/core/qtrd_pkg.sv
// Shared constants, types and register codes of the quiet tail RMS detector.
`default_nettype none

package qtrd_pkg;

  localparam int MAX_WINDOW  = 16384;
  localparam int SAMPLE_BITS = 16;

  localparam int PTR_W  = $clog2(MAX_WINDOW);
  localparam int CNT_W  = PTR_W + 1;
  localparam int SQ_W   = 2 * SAMPLE_BITS - 1;
  localparam int SUM_W  = SQ_W + PTR_W;

  localparam int WIN_W  = 15;
  localparam int THR_W  = 31;
  localparam int PROD_W = THR_W + CNT_W;
  localparam int CMP_W  = (WIN_W > CNT_W) ? WIN_W : CNT_W;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = THR_W;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_QUIET_THRESHOLD = CFG_IDX_W'(1);

  localparam logic [WIN_W-1:0] WIN_RESET = WIN_W'(4800);
  localparam logic [THR_W-1:0] THR_RESET = THR_W'(86974);

  localparam int QUEUE_DEPTH = 4;
  localparam int Q_PTR_W     = $clog2(QUEUE_DEPTH);
  localparam int Q_CNT_W     = Q_PTR_W + 1;

  localparam int OUT_DEPTH   = 4;
  localparam int O_PTR_W     = $clog2(OUT_DEPTH);
  localparam int O_CNT_W     = O_PTR_W + 1;

  typedef struct packed {
    logic [SQ_W-1:0] sq;
    logic            invalid;
    logic            last;
  } item_t;

  typedef struct packed {
    logic [WIN_W-1:0] window_length;
    logic [THR_W-1:0] threshold_sq;
  } cfg_t;

endpackage

`default_nettype wire

>>> rtl/core/qtrd_if.sv
// Valid/ready channel interfaces for samples in and decisions out.
`default_nettype none

interface qtrd_in_if;
  logic                                       valid;
  logic                                       ready;
  logic signed [qtrd_pkg::SAMPLE_BITS-1:0]    sample;
  logic                                       sample_invalid;
  logic                                       last_sample;

  modport source (output valid, output sample, output sample_invalid, output last_sample,
                  input ready);
  modport sink   (input valid, input sample, input sample_invalid, input last_sample,
                  output ready);
endinterface

interface qtrd_out_if;
  logic valid;
  logic ready;
  logic tail_is_quiet;

  modport source (output valid, output tail_is_quiet, input ready);
  modport sink   (input valid, input tail_is_quiet, output ready);
endinterface

`default_nettype wire

>>> rtl/core/qtrd_front.sv
// Front end: takes samples, squares them and tags them for the item queue.
`default_nettype none

module qtrd_front (
  qtrd_in_if.sink              in_ch,
  input  logic                 q_full,
  output logic                 push,
  output qtrd_pkg::item_t      item
);

  logic [qtrd_pkg::SAMPLE_BITS-1:0]   mag;
  logic [2*qtrd_pkg::SAMPLE_BITS-1:0] sq_full;

  // Magnitude of the most negative code still fits as unsigned.
  assign mag = in_ch.sample[qtrd_pkg::SAMPLE_BITS-1] ?
               (~in_ch.sample + qtrd_pkg::SAMPLE_BITS'(1)) : in_ch.sample;
  assign sq_full = (2*qtrd_pkg::SAMPLE_BITS)'(mag) * (2*qtrd_pkg::SAMPLE_BITS)'(mag);

  assign in_ch.ready  = !q_full;
  assign push         = in_ch.valid && !q_full;
  assign item.sq      = sq_full[qtrd_pkg::SQ_W-1:0];
  assign item.invalid = in_ch.sample_invalid;
  assign item.last    = in_ch.last_sample;

endmodule

`default_nettype wire

>>> rtl/core/qtrd_queue.sv
// Short item queue between front end and back end.
`default_nettype none

module qtrd_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  qtrd_pkg::item_t      wr_item,
  output logic                 full,
  output logic                 valid,
  output qtrd_pkg::item_t      rd_item,
  input  logic                 pop
);

  qtrd_pkg::item_t                 slot_r [qtrd_pkg::QUEUE_DEPTH];
  logic [qtrd_pkg::Q_PTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [qtrd_pkg::Q_PTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [qtrd_pkg::Q_CNT_W-1:0]    cnt_r, cnt_nxt;

  assign full    = (cnt_r == qtrd_pkg::Q_CNT_W'(qtrd_pkg::QUEUE_DEPTH));
  assign valid   = (cnt_r != '0);
  assign rd_item = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= wr_item;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/qtrd_back.sv
// Back end: prefix-sum ring, buffer counters, tail test and result queue.
`default_nettype none

module qtrd_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  qtrd_pkg::cfg_t       cfg,
  input  logic                 q_valid,
  input  qtrd_pkg::item_t      q_item,
  output logic                 q_pop,
  qtrd_out_if.source           out_ch
);

  // Ring holds the exclusive prefix sum (mod 2^SUM_W) at each sample's slot.
  logic [qtrd_pkg::SUM_W-1:0]  ring_r [qtrd_pkg::MAX_WINDOW];
  logic [qtrd_pkg::SUM_W-1:0]  rd_r;

  logic [qtrd_pkg::PTR_W-1:0]  wp_r, wp_nxt;
  logic [qtrd_pkg::SUM_W-1:0]  acc_r, acc_nxt;
  logic [qtrd_pkg::CNT_W-1:0]  seen_r, seen_nxt;
  logic [qtrd_pkg::CNT_W-1:0]  since_r, since_nxt;

  logic [qtrd_pkg::CNT_W-1:0]  win_eff;
  logic [qtrd_pkg::CNT_W-1:0]  seen_inc, since_inc;
  logic [qtrd_pkg::SUM_W-1:0]  acc_sum;
  logic [qtrd_pkg::PTR_W-1:0]  raddr;
  logic                        window_ok;
  logic                        pop_last;

  // Stage B: read data arrives
  logic                        vb_r;
  logic [qtrd_pkg::SUM_W-1:0]  accb_r, accpre_r;
  logic [qtrd_pkg::PROD_W-1:0] thrw_r;
  logic                        okb_r, bypb_r;

  // Stage C: window sum ready for compare
  logic                        vc_r;
  logic [qtrd_pkg::SUM_W-1:0]  diff_r;
  logic [qtrd_pkg::PROD_W-1:0] thrwc_r;
  logic                        okc_r;

  // Result queue
  logic                        res_r [qtrd_pkg::OUT_DEPTH];
  logic [qtrd_pkg::O_PTR_W-1:0] owr_r, ord_r;
  logic [qtrd_pkg::O_CNT_W-1:0] ocnt_r, ocnt_nxt;
  logic [qtrd_pkg::O_CNT_W-1:0] in_flight;
  logic                        out_xfer;
  logic                        quiet;

  always_comb begin
    if (qtrd_pkg::CMP_W'(cfg.window_length) > qtrd_pkg::CMP_W'(qtrd_pkg::MAX_WINDOW)) begin
      win_eff = qtrd_pkg::CNT_W'(qtrd_pkg::MAX_WINDOW);
    end else begin
      win_eff = qtrd_pkg::CNT_W'(cfg.window_length);
    end
  end

  // Hold a last item back until the result queue is sure to have room.
  assign in_flight = qtrd_pkg::O_CNT_W'(vb_r) + qtrd_pkg::O_CNT_W'(vc_r);
  assign q_pop     = q_valid && (!q_item.last ||
                     (ocnt_r + in_flight < qtrd_pkg::O_CNT_W'(qtrd_pkg::OUT_DEPTH)));
  assign pop_last  = q_pop && q_item.last;

  assign seen_inc  = (seen_r < qtrd_pkg::CNT_W'(qtrd_pkg::MAX_WINDOW)) ?
                     seen_r + 1'b1 : seen_r;
  assign since_inc = q_item.invalid ? '0 :
                     ((since_r < qtrd_pkg::CNT_W'(qtrd_pkg::MAX_WINDOW)) ?
                      since_r + 1'b1 : since_r);
  assign window_ok = (win_eff != '0) && (seen_inc >= win_eff) && (since_inc >= win_eff);
  assign acc_sum   = acc_r + qtrd_pkg::SUM_W'(q_item.sq);
  // Slot of the oldest sample in the window.
  assign raddr     = wp_r + qtrd_pkg::PTR_W'(1) - win_eff[qtrd_pkg::PTR_W-1:0];

  always_comb begin
    wp_nxt    = wp_r;
    acc_nxt   = acc_r;
    seen_nxt  = seen_r;
    since_nxt = since_r;
    if (q_pop) begin
      if (q_item.last) begin
        wp_nxt    = '0;
        acc_nxt   = '0;
        seen_nxt  = '0;
        since_nxt = '0;
      end else begin
        wp_nxt    = wp_r + 1'b1;
        acc_nxt   = acc_sum;
        seen_nxt  = seen_inc;
        since_nxt = since_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r    <= '0;
      acc_r   <= '0;
      seen_r  <= '0;
      since_r <= '0;
      vb_r    <= 1'b0;
      vc_r    <= 1'b0;
    end else begin
      wp_r    <= wp_nxt;
      acc_r   <= acc_nxt;
      seen_r  <= seen_nxt;
      since_r <= since_nxt;
      vb_r    <= pop_last;
      vc_r    <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      ring_r[wp_r] <= acc_r;
    end
    if (pop_last) begin
      rd_r <= ring_r[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (pop_last) begin
      accb_r   <= acc_sum;
      accpre_r <= acc_r;
      thrw_r   <= qtrd_pkg::PROD_W'(cfg.threshold_sq) * qtrd_pkg::PROD_W'(win_eff);
      okb_r    <= window_ok;
      // One-sample window: the needed prefix is the one being written now.
      bypb_r   <= (raddr == wp_r);
    end
    if (vb_r) begin
      diff_r  <= accb_r - (bypb_r ? accpre_r : rd_r);
      thrwc_r <= thrw_r;
      okc_r   <= okb_r;
    end
  end

  assign quiet    = okc_r && (qtrd_pkg::PROD_W'(diff_r) < thrwc_r);
  assign out_xfer = out_ch.valid && out_ch.ready;

  always_comb begin
    ocnt_nxt = ocnt_r;
    if (vc_r && !out_xfer) begin
      ocnt_nxt = ocnt_r + 1'b1;
    end else if (out_xfer && !vc_r) begin
      ocnt_nxt = ocnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owr_r  <= '0;
      ord_r  <= '0;
      ocnt_r <= '0;
    end else begin
      if (vc_r) begin
        owr_r <= owr_r + 1'b1;
      end
      if (out_xfer) begin
        ord_r <= ord_r + 1'b1;
      end
      ocnt_r <= ocnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (vc_r) begin
      res_r[owr_r] <= quiet;
    end
  end

  assign out_ch.valid         = (ocnt_r != '0);
  assign out_ch.tail_is_quiet = res_r[ord_r];

endmodule

`default_nettype wire

>>> rtl/core/quiet_tail_rms_detector_unit.sv
// Top level of the quiet tail RMS detector: configuration registers and block wiring.
`default_nettype none

// Takes one signed Q1.15 sample per transfer and, on the sample flagged last,
// delivers one decision: tail_is_quiet is 1 when the window is nonzero, the
// buffer held at least that many samples, none of them was flagged invalid and
// the sum of their squares is below quiet_threshold_sq times the window
// length. Window lengths above 16384 act as 16384. Samples are taken at one
// per clock cycle while the item queue has room; the ring memory sets that rate,
// as it takes one write per sample and one read per last sample. A decision
// passes the item queue, stages B and C and the result queue, and up to four
// decisions are held while output stalls. The ring needs no clearing after reset.
// Write cfg_index/cfg_wdata with cfg_we only while no buffer is in progress.
module quiet_tail_rms_detector_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  qtrd_in_if.sink                             in_ch,
  qtrd_out_if.source                          out_ch,
  input  logic                                cfg_we,
  input  logic [qtrd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [qtrd_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  qtrd_pkg::cfg_t   cfg_r, cfg_nxt;
  qtrd_pkg::item_t  push_item, head_item;
  logic             push, q_full, q_valid, q_pop;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        qtrd_pkg::REG_WINDOW_LENGTH:
          cfg_nxt.window_length = cfg_wdata[qtrd_pkg::WIN_W-1:0];
        qtrd_pkg::REG_QUIET_THRESHOLD:
          cfg_nxt.threshold_sq  = cfg_wdata[qtrd_pkg::THR_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.window_length <= qtrd_pkg::WIN_RESET;
      cfg_r.threshold_sq  <= qtrd_pkg::THR_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  qtrd_front u_front (
    .in_ch  (in_ch),
    .q_full (q_full),
    .push   (push),
    .item   (push_item)
  );

  qtrd_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .wr_item (push_item),
    .full    (q_full),
    .valid   (q_valid),
    .rd_item (head_item),
    .pop     (q_pop)
  );

  qtrd_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .q_valid (q_valid),
    .q_item  (head_item),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

`default_nettype wire

>>> rtl/core/qtrd_checker.sv
// Port-level checks of the quiet tail RMS detector, bound to its top level.
`default_nettype none

module qtrd_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic in_last,
  input logic out_valid,
  input logic out_ready,
  input logic out_quiet
);

  localparam int PEND_W   = 4;
  // Queued last samples plus decisions in the pipeline and result queue.
  localparam int PEND_MAX = 8;

  logic              last_xfer, out_xfer;
  logic [PEND_W-1:0] pend_r, pend_nxt;

  assign last_xfer = in_valid && in_ready && in_last;
  assign out_xfer  = out_valid && out_ready;

  always_comb begin
    pend_nxt = pend_r;
    if (last_xfer && !out_xfer) begin
      pend_nxt = pend_r + 1'b1;
    end else if (out_xfer && !last_xfer) begin
      pend_nxt = pend_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result offered right after reset");

  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_quiet))
    else $error("stalled result changed or dropped");

  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != '0)
    else $error("result offered with no last sample outstanding");

  a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r <= PEND_W'(PEND_MAX))
    else $error("more decisions outstanding than the block can hold");

endmodule

bind quiet_tail_rms_detector_unit qtrd_checker u_qtrd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_last   (in_ch.last_sample),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_quiet (out_ch.tail_is_quiet)
);

`default_nettype wire
